// File: rtl/mmbu_pkg.sv
// Shared types, codes and defaults for the mapped memory bus unit.
// No dependencies; imported by every other file of the block.
package mmbu_pkg;

    localparam int INSTR_BYTES_DEF = 4096;
    localparam int DATA_BYTES_DEF  = 4096;

    localparam logic [31:0] INSTR_BASE_RST = 32'h1000_0000;
    localparam logic [31:0] DATA_BASE_RST  = 32'h2000_0000;
    localparam logic [31:0] GETC_BASE_RST  = 32'h3000_0000;
    localparam logic [31:0] PUTC_BASE_RST  = 32'h3000_0004;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_LOAD  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_HALF = 2'd1,
        SZ_WORD = 2'd2
    } size_t;

    typedef enum logic [1:0] {
        CFG_INSTR_BASE = 2'd0,
        CFG_DATA_BASE  = 2'd1,
        CFG_GETC_BASE  = 2'd2,
        CFG_PUTC_BASE  = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_DIRECT,
        KIND_RD,
        KIND_WR
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_RD_ISSUE,
        ST_RD_ACC,
        ST_WR_CHECK,
        ST_WR_LANE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [31:0] instr_base;
        logic [31:0] data_base;
        logic [31:0] getc_base;
        logic [31:0] putc_base;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic clr_wr;
        logic take_direct;
        logic rd_issue;
        logic rd_acc;
        logic wr_fail;
        logic lane_reset;
        logic lane_inc;
        logic wr_lane;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  clr_last;
        logic  lane_last;
        logic  lane_ok;
    } dp_status_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        char_taken;
        logic        put_valid;
        logic [7:0]  put_char;
        logic        fault;
    } result_t;

endpackage

// File: rtl/mapped_memory_bus_unit.sv
// Mapped memory bus unit, top level: configuration registers, output register,
// controller and datapath. Depends on mmbu_pkg, mmbu_ctrl, mmbu_datapath.
// One request at a time: in_stall stays high from acceptance until the result is
// registered. A read issues, then accumulates each lane from registered store reads;
// a write checks every lane, faults at its first unmapped lane, else writes the lanes.
// Loads, window halfword/word accesses and decode faults finish after decode; a result
// waits under out_stall. Reset: data store cleared with in_stall high; config writes
// are taken throughout. Instruction store is not cleared.
module mapped_memory_bus_unit #(
    parameter int INSTR_BYTES = mmbu_pkg::INSTR_BYTES_DEF,
    parameter int DATA_BYTES  = mmbu_pkg::DATA_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        cmd,
    input  logic [1:0]        access_size,
    input  logic [31:0]       address,
    input  logic [31:0]       write_data,
    input  logic signed [8:0] char_in,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [31:0]       read_data,
    output logic              char_taken,
    output logic              put_valid,
    output logic [7:0]        put_char,
    output logic              fault,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import mmbu_pkg::*;

    cfg_t       cfg_reg;
    ctrl_cmd_t  ctl_cmd;
    dp_status_t dp_status;
    result_t    res;
    result_t    out_reg;
    logic       out_valid_reg;
    logic       out_free;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.instr_base <= INSTR_BASE_RST;
            cfg_reg.data_base  <= DATA_BASE_RST;
            cfg_reg.getc_base  <= GETC_BASE_RST;
            cfg_reg.putc_base  <= PUTC_BASE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_INSTR_BASE: cfg_reg.instr_base <= cfg_data;
                CFG_DATA_BASE:  cfg_reg.data_base  <= cfg_data;
                CFG_GETC_BASE:  cfg_reg.getc_base  <= cfg_data;
                CFG_PUTC_BASE:  cfg_reg.putc_base  <= cfg_data;
                default:        cfg_reg.putc_base  <= cfg_data;
            endcase
        end
    end

    mmbu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_free (out_free),
        .status   (dp_status),
        .cmd      (ctl_cmd)
    );

    mmbu_datapath #(
        .INSTR_BYTES (INSTR_BYTES),
        .DATA_BYTES  (DATA_BYTES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .cmd      (ctl_cmd),
        .status   (dp_status),
        .cmd_in   (cmd),
        .size_in  (access_size),
        .addr_in  (address),
        .wdata_in (write_data),
        .char_in  (char_in),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl_cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_cmd.finish)
        begin
            out_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = out_reg.read_data;
    assign char_taken = out_reg.char_taken;
    assign put_valid  = out_reg.put_valid;
    assign put_char   = out_reg.put_char;
    assign fault      = out_reg.fault;

endmodule

// File: rtl/mmbu_ctrl.sv
// Sequencer of the mapped memory bus unit: clearing pass, decode, lane walk.
// Depends on mmbu_pkg; drives the datapath by command struct only.
module mmbu_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                out_free,
    input  mmbu_pkg::dp_status_t status,
    output mmbu_pkg::ctrl_cmd_t  cmd
);
    import mmbu_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (status.kind)
                    KIND_RD:
                    begin
                        state_next = ST_RD_ISSUE;
                    end
                    KIND_WR:
                    begin
                        state_next = ST_WR_CHECK;
                    end
                    default:
                    begin
                        cmd.take_direct = 1'b1;
                        state_next      = ST_FINISH;
                    end
                endcase
            end
            ST_RD_ISSUE:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_RD_ACC;
            end
            ST_RD_ACC:
            begin
                cmd.rd_acc   = 1'b1;
                cmd.lane_inc = 1'b1;
                state_next   = status.lane_last ? ST_FINISH : ST_RD_ISSUE;
            end
            ST_WR_CHECK:
            begin
                if (!status.lane_ok)
                begin
                    cmd.wr_fail = 1'b1;
                    state_next  = ST_FINISH;
                end
                else if (status.lane_last)
                begin
                    cmd.lane_reset = 1'b1;
                    state_next     = ST_WR_LANE;
                end
                else
                begin
                    cmd.lane_inc = 1'b1;
                end
            end
            ST_WR_LANE:
            begin
                cmd.wr_lane  = 1'b1;
                cmd.lane_inc = 1'b1;
                if (status.lane_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/mmbu_datapath.sv
// Datapath of the mapped memory bus unit: request registers, region decode,
// instruction and data stores, lane assembly. Depends on mmbu_pkg.
module mmbu_datapath #(
    parameter int INSTR_BYTES = mmbu_pkg::INSTR_BYTES_DEF,
    parameter int DATA_BYTES  = mmbu_pkg::DATA_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mmbu_pkg::cfg_t       cfg,
    input  mmbu_pkg::ctrl_cmd_t  cmd,
    output mmbu_pkg::dp_status_t status,
    input  logic [1:0]           cmd_in,
    input  logic [1:0]           size_in,
    input  logic [31:0]          addr_in,
    input  logic [31:0]          wdata_in,
    input  logic signed [8:0]    char_in,
    output mmbu_pkg::result_t    res
);
    import mmbu_pkg::*;

    localparam int IW = $clog2(INSTR_BYTES);
    localparam int DW = $clog2(DATA_BYTES);
    localparam logic [31:0] INSTR_SIZE = 32'(INSTR_BYTES);
    localparam logic [31:0] DATA_SIZE  = 32'(DATA_BYTES);
    localparam logic [31:0] WIN_SIZE   = 32'd4;

    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_INSTR,
        SRC_DATA,
        SRC_GETC
    } src_t;

    function automatic logic in_win(input logic [31:0] a, input logic [31:0] base,
                                    input logic [31:0] size);
        return (a >= base) && ((a - base) < size);
    endfunction

    logic [7:0] instr_mem [INSTR_BYTES];
    logic [7:0] data_mem  [DATA_BYTES];

    logic [1:0]  cmd_reg;
    logic [1:0]  size_reg;
    logic [31:0] addr_reg;
    logic [31:0] wd_reg;
    logic [8:0]  char_reg;

    logic [1:0]    lane_reg;
    logic [DW-1:0] clr_cnt_reg;

    src_t       src_reg;
    logic [7:0] gbyte_reg;
    logic [7:0] instr_q_reg;
    logic [7:0] data_q_reg;

    logic [31:0] rd_reg;
    logic        taken_reg;
    logic        pv_reg;
    logic [7:0]  pc_reg;
    logic        fault_reg;

    logic [31:0] cv;
    logic [1:0]  lane_last_idx;
    logic [31:0] lane_addr;
    logic [31:0] off_i;
    logic [31:0] off_d;
    logic        hit_i;
    logic        hit_d;
    logic        hit_g;
    logic        hit_p;
    logic [7:0]  gbyte;
    logic [7:0]  wbyte;
    logic [7:0]  lane_byte;

    kind_t       kind;
    logic [31:0] d_rd;
    logic        d_taken;
    logic        d_pv;
    logic [7:0]  d_pc;
    logic        d_fault;
    logic        win_g;
    logic        win_p;
    logic        load_ok;

    assign cv = {{23{char_reg[8]}}, char_reg};

    always_comb
    begin
        case (size_reg)
            SZ_HALF: lane_last_idx = 2'd1;
            SZ_WORD: lane_last_idx = 2'd3;
            default: lane_last_idx = 2'd0;
        endcase
    end

    assign lane_addr = {addr_reg[31:2], addr_reg[1:0] + lane_reg};
    assign off_i     = lane_addr - cfg.instr_base;
    assign off_d     = lane_addr - cfg.data_base;
    assign hit_i     = in_win(lane_addr, cfg.instr_base, INSTR_SIZE);
    assign hit_d     = in_win(lane_addr, cfg.data_base, DATA_SIZE);
    assign hit_g     = in_win(lane_addr, cfg.getc_base, WIN_SIZE);
    assign hit_p     = in_win(lane_addr, cfg.putc_base, WIN_SIZE);

    always_comb
    begin
        case (lane_addr[1:0])
            2'd0:    gbyte = cv[31:24];
            2'd1:    gbyte = cv[23:16];
            2'd2:    gbyte = cv[15:8];
            default: gbyte = cv[7:0];
        endcase
    end

    always_comb
    begin
        case (lane_last_idx - lane_reg)
            2'd0:    wbyte = wd_reg[7:0];
            2'd1:    wbyte = wd_reg[15:8];
            2'd2:    wbyte = wd_reg[23:16];
            default: wbyte = wd_reg[31:24];
        endcase
    end

    always_comb
    begin
        case (src_reg)
            SRC_INSTR: lane_byte = instr_q_reg;
            SRC_DATA:  lane_byte = data_q_reg;
            SRC_GETC:  lane_byte = gbyte_reg;
            default:   lane_byte = 8'h00;
        endcase
    end

    // whole-request decode: window halfword/word accesses, loads and decode faults finish here
    assign win_g   = in_win(addr_reg, cfg.getc_base, WIN_SIZE);
    assign win_p   = in_win(addr_reg, cfg.putc_base, WIN_SIZE);
    assign load_ok = addr_reg < INSTR_SIZE;

    always_comb
    begin
        kind    = KIND_DIRECT;
        d_rd    = '0;
        d_taken = 1'b0;
        d_pv    = 1'b0;
        d_pc    = '0;
        d_fault = 1'b1;
        unique case (cmd_reg)
            CMD_LOAD:
            begin
                d_fault = !load_ok;
            end
            CMD_READ:
            begin
                unique case (size_reg)
                    SZ_BYTE:
                    begin
                        kind = KIND_RD;
                    end
                    SZ_HALF:
                    begin
                        if (win_g && !addr_reg[0])
                        begin
                            d_fault = 1'b0;
                            d_taken = 1'b1;
                            d_rd    = addr_reg[1] ? {16'h0, cv[15:0]} : {16'h0, cv[31:16]};
                        end
                        else if (!win_g && !addr_reg[0])
                        begin
                            kind = KIND_RD;
                        end
                    end
                    SZ_WORD:
                    begin
                        if (win_g && addr_reg == cfg.getc_base)
                        begin
                            d_fault = 1'b0;
                            d_taken = 1'b1;
                            d_rd    = cv;
                        end
                        else if (!win_g && addr_reg[1:0] == 2'd0)
                        begin
                            kind = KIND_RD;
                        end
                    end
                    default:
                    begin
                        d_fault = 1'b1;
                    end
                endcase
            end
            CMD_WRITE:
            begin
                unique case (size_reg)
                    SZ_BYTE:
                    begin
                        kind = KIND_WR;
                    end
                    SZ_HALF:
                    begin
                        if (win_p && !addr_reg[0])
                        begin
                            d_fault = 1'b0;
                            d_pv    = 1'b1;
                            d_pc    = addr_reg[1] ? wd_reg[7:0] : 8'h00;
                        end
                        else if (!win_p && !addr_reg[0])
                        begin
                            kind = KIND_WR;
                        end
                    end
                    SZ_WORD:
                    begin
                        if (win_p && addr_reg == cfg.putc_base)
                        begin
                            d_fault = 1'b0;
                            d_pv    = 1'b1;
                            d_pc    = wd_reg[7:0];
                        end
                        else if (!win_p && addr_reg[1:0] == 2'd0)
                        begin
                            kind = KIND_WR;
                        end
                    end
                    default:
                    begin
                        d_fault = 1'b1;
                    end
                endcase
            end
            default:
            begin
                d_fault = 1'b1;
            end
        endcase
    end

    assign status.kind      = kind;
    assign status.clr_last  = clr_cnt_reg == DW'(DATA_BYTES - 1);
    assign status.lane_last = lane_reg == lane_last_idx;
    assign status.lane_ok   = hit_p || hit_d;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg  <= cmd_in;
            size_reg <= size_in;
            addr_reg <= addr_in;
            wd_reg   <= wdata_in;
            char_reg <= char_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            lane_reg    <= '0;
        end
        else
        begin
            if (cmd.clr_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.capture || cmd.lane_reset)
            begin
                lane_reg <= '0;
            end
            else if (cmd.lane_inc)
            begin
                lane_reg <= lane_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_direct && cmd_reg == CMD_LOAD && load_ok)
        begin
            instr_mem[addr_reg[IW-1:0]] <= wd_reg[7:0];
        end
        if (cmd.rd_issue)
        begin
            instr_q_reg <= instr_mem[off_i[IW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
        begin
            data_mem[clr_cnt_reg] <= 8'h00;
        end
        else if (cmd.wr_lane && !hit_p)
        begin
            data_mem[off_d[DW-1:0]] <= wbyte;
        end
        if (cmd.rd_issue)
        begin
            data_q_reg <= data_mem[off_d[DW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            gbyte_reg <= gbyte;
            if (hit_i)
            begin
                src_reg <= SRC_INSTR;
            end
            else if (hit_d)
            begin
                src_reg <= SRC_DATA;
            end
            else if (hit_g)
            begin
                src_reg <= SRC_GETC;
            end
            else
            begin
                src_reg <= SRC_NONE;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rd_reg    <= '0;
            taken_reg <= 1'b0;
            pv_reg    <= 1'b0;
            pc_reg    <= '0;
            fault_reg <= 1'b0;
        end
        else if (cmd.take_direct)
        begin
            rd_reg    <= d_rd;
            taken_reg <= d_taken;
            pv_reg    <= d_pv;
            pc_reg    <= d_pc;
            fault_reg <= d_fault;
        end
        else if (cmd.rd_acc)
        begin
            rd_reg <= {rd_reg[23:0], lane_byte};
            if (src_reg == SRC_GETC)
            begin
                taken_reg <= 1'b1;
            end
            if (src_reg == SRC_NONE)
            begin
                fault_reg <= 1'b1;
            end
        end
        else if (cmd.wr_fail)
        begin
            fault_reg <= 1'b1;
        end
        else if (cmd.wr_lane && hit_p)
        begin
            pv_reg <= 1'b1;
            pc_reg <= (lane_addr[1:0] == 2'd3) ? wbyte : 8'h00;
        end
    end

    // a faulted request reports nothing but the fault
    assign res.read_data  = fault_reg ? 32'h0 : rd_reg;
    assign res.char_taken = taken_reg && !fault_reg;
    assign res.put_valid  = pv_reg && !fault_reg;
    assign res.put_char   = fault_reg ? 8'h00 : pc_reg;
    assign res.fault      = fault_reg;

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for mapped_memory_bus_unit: a stimulus table, then random
// requests under several address maps, each result checked against the table's expected
// value or an in-line predictor. Depends on rtl/mmbu_pkg.sv and rtl/mapped_memory_bus_unit.sv.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mmbu_pkg::*;

    localparam logic [1:0] CMD_BAD = 2'd3;
    localparam logic [1:0] SZ_BAD  = 2'd3;
    localparam int RANDOM_PER_MAP  = 175;
    localparam int MAP_COUNT       = 7;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  size;
        logic [31:0] addr;
        logic [31:0] wdata;
        logic [8:0]  ch;
    } access_t;

    typedef struct {
        access_t rq;
        bit      fixed;
        result_t want;
    } vector_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        cmd;
    logic [1:0]        access_size;
    logic [31:0]       address;
    logic [31:0]       write_data;
    logic signed [8:0] char_in;
    logic              out_valid;
    logic              out_stall;
    logic [31:0]       read_data;
    logic              char_taken;
    logic              put_valid;
    logic [7:0]        put_char;
    logic              fault;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_index;
    logic [31:0]       cfg_data;

    cfg_t       addr_map;
    logic [7:0] instr_img [INSTR_BYTES_DEF];
    bit         instr_set [INSTR_BYTES_DEF];
    logic [7:0] data_img  [DATA_BYTES_DEF];

    result_t due_results[$];
    vector_t plan[$];

    bit calm;
    bit hold_go;
    int errors;
    int accepted;
    int results_seen;
    int faults_seen;

    mapped_memory_bus_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .access_size (access_size),
        .address     (address),
        .write_data  (write_data),
        .char_in     (char_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_data   (read_data),
        .char_taken  (char_taken),
        .put_valid   (put_valid),
        .put_char    (put_char),
        .fault       (fault),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic bit hits_region(logic [31:0] a, logic [31:0] base, logic [31:0] span);
        logic [31:0] off;
        off = a - base;
        return (a >= base) && (off < span);
    endfunction

    function automatic logic [7:0] lane_byte(logic [31:0] a, logic [31:0] cv,
                                             inout bit got, inout bit ok);
        logic [31:0] sh;
        int k;
        if (hits_region(a, addr_map.instr_base, INSTR_BYTES_DEF))
            return instr_img[a - addr_map.instr_base];
        if (hits_region(a, addr_map.data_base, DATA_BYTES_DEF))
            return data_img[a - addr_map.data_base];
        if (hits_region(a, addr_map.getc_base, 4))
        begin
            got = 1'b1;
            k = a[1:0];
            sh = $signed(cv) >>> (8 * (3 - k));
            return sh[7:0];
        end
        ok = 1'b0;
        return 8'h00;
    endfunction

    // Applies one request to the predictor state and returns its result.
    function automatic result_t bus_access_outcome(access_t r);
        result_t res;
        logic [31:0] cv, acc, a, w;
        bit got, ok, bad;
        int n;
        res = '0;
        acc = '0;
        got = 1'b0;
        ok  = 1'b1;
        bad = 1'b0;
        cv  = {{23{r.ch[8]}}, r.ch};
        n   = (r.size == SZ_BYTE) ? 1 : (r.size == SZ_HALF) ? 2 : 4;
        if (r.cmd == CMD_LOAD)
        begin
            if (r.addr < INSTR_BYTES_DEF)
            begin
                instr_img[r.addr] = r.wdata[7:0];
                instr_set[r.addr] = 1'b1;
            end
            else
                bad = 1'b1;
        end
        else if ((r.cmd != CMD_READ && r.cmd != CMD_WRITE) || r.size == SZ_BAD)
            bad = 1'b1;
        else if (r.cmd == CMD_READ)
        begin
            if (n > 1 && hits_region(r.addr, addr_map.getc_base, 4))
            begin
                if ((n == 2 && r.addr[0]) || (n == 4 && r.addr != addr_map.getc_base))
                    bad = 1'b1;
                else
                begin
                    w = $signed(cv) >>> 16;
                    res.char_taken = 1'b1;
                    if (n == 4)
                        res.read_data = cv;
                    else if (r.addr[1:0] == 2'd0)
                        res.read_data = {16'h0000, w[15:0]};
                    else
                        res.read_data = {16'h0000, cv[15:0]};
                end
            end
            else if ((n == 2 && r.addr[0]) || (n == 4 && r.addr[1:0] != 2'd0))
                bad = 1'b1;
            else
            begin
                for (int i = 0; i < n; i++)
                    acc = {acc[23:0], lane_byte(r.addr + i, cv, got, ok)};
                if (!ok)
                    bad = 1'b1;
                else
                begin
                    res.read_data  = acc;
                    res.char_taken = got;
                end
            end
        end
        else
        begin
            if (n > 1 && hits_region(r.addr, addr_map.putc_base, 4))
            begin
                if ((n == 2 && r.addr[0]) || (n == 4 && r.addr != addr_map.putc_base))
                    bad = 1'b1;
                else
                begin
                    res.put_valid = 1'b1;
                    res.put_char  = (n == 2 && r.addr[1:0] == 2'd0) ? 8'h00 : r.wdata[7:0];
                end
            end
            else if ((n == 2 && r.addr[0]) || (n == 4 && r.addr[1:0] != 2'd0))
                bad = 1'b1;
            else
            begin
                for (int i = 0; i < n; i++)
                begin
                    a = r.addr + i;
                    if (!hits_region(a, addr_map.putc_base, 4) &&
                        !hits_region(a, addr_map.data_base, DATA_BYTES_DEF))
                        ok = 1'b0;
                end
                if (!ok)
                    bad = 1'b1;
                else
                    for (int i = 0; i < n; i++)
                    begin
                        a = r.addr + i;
                        w = r.wdata >> (8 * (n - 1 - i));
                        if (hits_region(a, addr_map.putc_base, 4))
                        begin
                            res.put_valid = 1'b1;
                            res.put_char  = (a[1:0] == 2'd3) ? w[7:0] : 8'h00;
                        end
                        else
                            data_img[a - addr_map.data_base] = w[7:0];
                    end
            end
        end
        if (bad)
        begin
            res = '0;
            res.fault = 1'b1;
        end
        return res;
    endfunction

    function automatic result_t outcome(logic [31:0] rd, bit tk, bit pv, logic [7:0] pc, bit f);
        return '{rd, tk, pv, pc, f};
    endfunction

    function automatic void plan_row(logic [1:0] c, logic [1:0] s, logic [31:0] a,
                                     logic [31:0] wd, logic [8:0] ch,
                                     bit fixed = 1'b0, result_t want = '0);
        vector_t v;
        v.rq    = '{c, s, a, wd, ch};
        v.fixed = fixed;
        v.want  = want;
        plan.push_back(v);
    endfunction

    function automatic logic [31:0] random_address();
        logic [31:0] bases [4];
        bases = '{addr_map.instr_base, addr_map.data_base, addr_map.getc_base,
                  addr_map.putc_base};
        case ($urandom_range(11))
            0, 1, 2, 3: return addr_map.data_base + $urandom_range(DATA_BYTES_DEF - 1);
            4, 5:       return addr_map.instr_base + $urandom_range(INSTR_BYTES_DEF - 1);
            6, 7:       return addr_map.getc_base + $urandom_range(3);
            8, 9:       return addr_map.putc_base + $urandom_range(3);
            10:         return bases[$urandom_range(3)] + $urandom_range(4111) - 8;
            default:    return $urandom;
        endcase
    endfunction

    function automatic access_t random_access();
        access_t r;
        int pick;
        pick   = $urandom_range(99);
        r.cmd  = (pick < 45) ? CMD_READ : (pick < 87) ? CMD_WRITE : (pick < 97) ? CMD_LOAD : CMD_BAD;
        pick   = $urandom_range(99);
        r.size = (pick < 32) ? SZ_BYTE : (pick < 64) ? SZ_HALF : (pick < 97) ? SZ_WORD : SZ_BAD;
        r.wdata = $urandom;
        r.ch    = ($urandom_range(9) == 0) ? 9'h1FF : {1'b0, 8'($urandom)};
        if (r.cmd == CMD_LOAD)
            r.addr = ($urandom_range(9) == 0) ? $urandom_range(32'hFFFF_FFFF, INSTR_BYTES_DEF)
                                              : $urandom_range(INSTR_BYTES_DEF - 1);
        else
        begin
            r.addr = random_address();
            if (r.size == SZ_HALF && $urandom_range(9) != 0)
                r.addr[0] = 1'b0;
            if (r.size == SZ_WORD && $urandom_range(9) != 0)
                r.addr[1:0] = 2'd0;
        end
        return r;
    endfunction

    // A read that would touch a never-loaded instruction byte becomes a load of that byte.
    function automatic void keep_instr_defined(inout access_t r);
        logic [31:0] a, off;
        bit swapped;
        int n;
        swapped = 1'b0;
        n = (r.size == SZ_BYTE) ? 1 : (r.size == SZ_HALF) ? 2 : 4;
        if (r.cmd == CMD_READ && r.size != SZ_BAD)
            for (int i = 0; i < n; i++)
            begin
                a   = r.addr + i;
                off = a - addr_map.instr_base;
                if (!swapped && hits_region(a, addr_map.instr_base, INSTR_BYTES_DEF) &&
                    !instr_set[off])
                begin
                    r.cmd   = CMD_LOAD;
                    r.addr  = off;
                    swapped = 1'b1;
                end
            end
    endfunction

    task automatic offer(access_t r, bit fixed, result_t want);
        result_t calc;
        while (!calm && $urandom_range(99) < 10)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= r.cmd;
        access_size <= r.size;
        address     <= r.addr;
        write_data  <= r.wdata;
        char_in     <= r.ch;
        do
            @(posedge clk);
        while (in_stall);
        calc = bus_access_outcome(r);
        due_results.push_back(fixed ? want : calc);
        accepted++;
        @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_INSTR_BASE: addr_map.instr_base = val;
            CFG_DATA_BASE:  addr_map.data_base  = val;
            CFG_GETC_BASE:  addr_map.getc_base  = val;
            CFG_PUTC_BASE:  addr_map.putc_base  = val;
        endcase
        @(negedge clk);
    endtask

    task automatic apply_map(cfg_t m);
        write_reg(CFG_INSTR_BASE, m.instr_base);
        write_reg(CFG_DATA_BASE, m.data_base);
        write_reg(CFG_GETC_BASE, m.getc_base);
        write_reg(CFG_PUTC_BASE, m.putc_base);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    initial
    begin : drain_side
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go)
            begin
                hold_go   = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(99) < 10);
        end
    end

    always @(posedge clk)
    begin : score
        result_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{read_data, char_taken, put_valid, put_char, fault};
            results_seen++;
            if (got.fault)
                faults_seen++;
            if (due_results.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("read_data", want.read_data, got.read_data);
                check_field("char_taken", want.char_taken, got.char_taken);
                check_field("put_valid", want.put_valid, got.put_valid);
                check_field("put_char", want.put_char, got.put_char);
                check_field("fault", want.fault, got.fault);
            end
        end
    end

    initial
    begin : stimulus
        cfg_t maps [MAP_COUNT];
        access_t r;
        result_t nil, bad;
        int served;
        in_valid    = 1'b0;
        cmd         = CMD_READ;
        access_size = SZ_BYTE;
        address     = '0;
        write_data  = '0;
        char_in     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_INSTR_BASE;
        cfg_data    = '0;
        calm        = 1'b0;
        hold_go     = 1'b0;
        errors      = 0;
        served      = 0;
        addr_map    = '{INSTR_BASE_RST, DATA_BASE_RST, GETC_BASE_RST, PUTC_BASE_RST};
        foreach (data_img[i])
            data_img[i] = 8'h00;
        foreach (instr_img[i])
            instr_img[i] = 8'h00;

        maps[0] = '{INSTR_BASE_RST, DATA_BASE_RST, GETC_BASE_RST, PUTC_BASE_RST};
        maps[1] = '{32'h0000_0000, 32'h0000_1000, 32'h0000_2000, 32'h0000_2004};
        maps[2] = '{32'hFFFF_F000, 32'hFFFF_E000, 32'hFFFF_DFF8, 32'hFFFF_DFFC};
        maps[3] = '{32'h4000_0000, 32'h4000_0800, 32'h4000_0FFC, 32'h4000_1000};
        maps[4] = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
        maps[5] = '{$urandom, $urandom, $urandom & 32'hFFFF_FFFC, $urandom & 32'hFFFF_FFFC};
        maps[6] = '{$urandom, $urandom, $urandom & 32'hFFFF_FFFC, $urandom & 32'hFFFF_FFFC};
        maps[6].putc_base = maps[6].getc_base + 32'd4;

        rst_n = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        apply_map(maps[0]);

        nil = outcome(32'h0, 1'b0, 1'b0, 8'h00, 1'b0);
        bad = outcome(32'h0, 1'b0, 1'b0, 8'h00, 1'b1);
        plan_row(CMD_READ,  SZ_WORD, DATA_BASE_RST,         32'h0, 9'h000, 1'b1, nil);
        plan_row(CMD_LOAD,  SZ_BYTE, 32'd0,                 32'h12, 9'h000, 1'b1, nil);
        plan_row(CMD_LOAD,  SZ_HALF, 32'd1,                 32'h34, 9'h000);
        plan_row(CMD_LOAD,  SZ_WORD, 32'd2,                 32'h56, 9'h000);
        plan_row(CMD_LOAD,  SZ_BAD,  32'd3,                 32'h78, 9'h000);
        plan_row(CMD_LOAD,  SZ_BYTE, 32'd4095,              32'hFFFF_FFA5, 9'h000, 1'b1, nil);
        plan_row(CMD_LOAD,  SZ_BYTE, 32'd4096,              32'h11, 9'h000, 1'b1, bad);
        plan_row(CMD_LOAD,  SZ_BYTE, 32'hFFFF_FFFF,         32'h11, 9'h000, 1'b1, bad);
        plan_row(CMD_READ,  SZ_WORD, INSTR_BASE_RST,        32'h0, 9'h000);
        plan_row(CMD_READ,  SZ_BYTE, INSTR_BASE_RST + 4095, 32'h0, 9'h000);
        plan_row(CMD_WRITE, SZ_WORD, DATA_BASE_RST,         32'hDEAD_BEEF, 9'h000, 1'b1, nil);
        plan_row(CMD_READ,  SZ_HALF, DATA_BASE_RST + 2,     32'h0, 9'h000);
        plan_row(CMD_WRITE, SZ_HALF, DATA_BASE_RST + 4094,  32'hFFFF_FFFF, 9'h000);
        plan_row(CMD_READ,  SZ_WORD, DATA_BASE_RST + 4092,  32'h0, 9'h000);
        plan_row(CMD_READ,  SZ_WORD, GETC_BASE_RST,         32'h0, 9'h1FF, 1'b1,
                 outcome(32'hFFFF_FFFF, 1'b1, 1'b0, 8'h00, 1'b0));
        plan_row(CMD_READ,  SZ_BYTE, GETC_BASE_RST + 3,     32'h0, 9'h041, 1'b1,
                 outcome(32'h41, 1'b1, 1'b0, 8'h00, 1'b0));
        plan_row(CMD_READ,  SZ_BYTE, GETC_BASE_RST,         32'h0, 9'h0FF);
        plan_row(CMD_READ,  SZ_HALF, GETC_BASE_RST,         32'h0, 9'h1FF, 1'b1,
                 outcome(32'hFFFF, 1'b1, 1'b0, 8'h00, 1'b0));
        plan_row(CMD_READ,  SZ_HALF, GETC_BASE_RST + 2,     32'h0, 9'h0FF);
        plan_row(CMD_READ,  SZ_HALF, GETC_BASE_RST + 1,     32'h0, 9'h041, 1'b1, bad);
        plan_row(CMD_READ,  SZ_WORD, PUTC_BASE_RST,         32'h0, 9'h041, 1'b1, bad);
        plan_row(CMD_WRITE, SZ_WORD, PUTC_BASE_RST,         32'h1234_5678, 9'h000, 1'b1,
                 outcome(32'h0, 1'b0, 1'b1, 8'h78, 1'b0));
        plan_row(CMD_WRITE, SZ_BYTE, PUTC_BASE_RST + 3,     32'h55, 9'h000, 1'b1,
                 outcome(32'h0, 1'b0, 1'b1, 8'h55, 1'b0));
        plan_row(CMD_WRITE, SZ_BYTE, PUTC_BASE_RST + 1,     32'h55, 9'h000);
        plan_row(CMD_WRITE, SZ_HALF, PUTC_BASE_RST,         32'hABCD, 9'h000);
        plan_row(CMD_WRITE, SZ_HALF, PUTC_BASE_RST + 2,     32'hABCD, 9'h000);
        plan_row(CMD_WRITE, SZ_WORD, PUTC_BASE_RST + 2,     32'h1, 9'h000, 1'b1, bad);
        plan_row(CMD_WRITE, SZ_BYTE, INSTR_BASE_RST,        32'h1, 9'h000, 1'b1, bad);
        plan_row(CMD_READ,  SZ_WORD, DATA_BASE_RST + 2,     32'h0, 9'h000, 1'b1, bad);
        plan_row(CMD_BAD,   SZ_BYTE, DATA_BASE_RST,         32'h0, 9'h000, 1'b1, bad);
        plan_row(CMD_READ,  SZ_BAD,  DATA_BASE_RST,         32'h0, 9'h000, 1'b1, bad);

        foreach (plan[i])
            offer(plan[i].rq, plan[i].fixed, plan[i].want);

        for (int m = 0; m < MAP_COUNT; m++)
        begin
            if (m > 0)
            begin
                settle();
                apply_map(maps[m]);
            end
            for (int k = 0; k < RANDOM_PER_MAP; k++)
            begin
                if (served == 400)
                    hold_go = 1'b1;
                calm = (served >= 700 && served < 850);
                r = random_access();
                keep_instr_defined(r);
                offer(r, 1'b0, '0);
                served++;
            end
        end
        calm = 1'b0;
        settle();
        repeat (20) @(posedge clk);
        if (due_results.size() != 0)
        begin
            $error("%0d results never arrived", due_results.size());
            errors++;
        end

        $display("Sent %0d requests (table and random) over %0d address maps;", accepted,
                 MAP_COUNT);
        $display("compared %0d results, %0d of them faults.", results_seen, faults_seen);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
